// ===== sv/basr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bridge ADC serial reader package
// Shared types and constants for the serial readout of a two-wire bridge
// converter: sequencer and readout phase encodings and fixed field widths.
// ----------------------------------------------------------------------------
package basr_pkg;

  localparam int unsigned SUM_W    = 32;
  localparam int unsigned DIVCNT_W = 5;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned GAIN_W   = 2;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned NET_W    = 25;
  localparam int unsigned EXT_W    = 34;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic signed [EXT_W-1:0] NET_MAX = 34'sd16777215;
  localparam logic signed [EXT_W-1:0] NET_MIN = -34'sd16777215;

  typedef enum logic [1:0] {
    REG_GAIN_PULSES = 2'd0,
    REG_AVG_COUNT   = 2'd1,
    REG_ZERO_OFFSET = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_GAIN = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIN  = 2'd2,
    ST_OUT  = 2'd3
  } state_e;

endpackage

// ===== sv/bridge_adc_serial_reader_unit.sv =====
// ----------------------------------------------------------------------------
// Bridge ADC serial reader
// Drives the serial clock of a two-wire 24-bit bridge converter one half
// period per input transaction, shifts in the conversion word, averages a
// configured number of readings and reports them less a tare offset.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                        | Direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid_i, in_ready_o, dout_level_i           | in
//  output   | out_valid_o, out_ready_i, sck_level_o,         | out
//           | sample_valid_o, net_value_o, busy_res_o        |
//  config   | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//           | pready                                         |
//
// A transaction that completes no average is accepted in the idle state and
// its result is presented from the output state. A transaction that completes
// an average passes from the idle state through the divide state, where the
// restoring divider produces one quotient bit per cycle, and then through the
// final state for the tare subtraction and saturation to the output state.
// Only one transaction is in flight; the input stays stalled until its result
// has been taken. Reset is asynchronous and returns all registers to their power-on values; no clearing pass is needed.

module bridge_adc_serial_reader_unit #(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  dout_level_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  sck_level_o,
  output logic                                  sample_valid_o,
  output logic signed [basr_pkg::NET_W-1:0]     net_value_o,
  output logic                                  busy_res_o,

  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [basr_pkg::PADDR_W-1:0]   paddr,
  input  logic        [basr_pkg::PDATA_W-1:0]   pwdata,
  output logic        [basr_pkg::PDATA_W-1:0]   prdata,
  output logic                                  pready
);

  localparam int unsigned PIDX_W = $clog2(DATA_BITS + 1);
  localparam int unsigned SUM_W  = basr_pkg::SUM_W;
  localparam int unsigned CNT_W  = basr_pkg::COUNT_W;

  logic [basr_pkg::GAIN_W-1:0]          gain_q;
  logic [CNT_W-1:0]                     avg_count_q;
  logic [basr_pkg::OFFSET_W-1:0]        offset_q;

  basr_pkg::phase_e                     phase_q, phase_d;
  logic                                 clk_high_q, clk_high_d;
  logic [PIDX_W-1:0]                    pidx_q, pidx_d;
  logic [DATA_BITS-1:0]                 shift_q, shift_d;
  logic [SUM_W-1:0]                     sum_q, sum_d;
  logic [CNT_W-1:0]                     taken_q, taken_d;

  basr_pkg::state_e                     state_q, state_d;
  logic [basr_pkg::DIVCNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic [SUM_W-1:0]                     quo_q, quo_d;
  logic [CNT_W-1:0]                     rem_q, rem_d;
  logic [CNT_W-1:0]                     divisor_q, divisor_d;
  logic                                 neg_q, neg_d;

  logic                                 sck_q, sck_d;
  logic                                 valid_q, valid_d;
  logic signed [basr_pkg::NET_W-1:0]    net_q, net_d;
  logic                                 busy_q, busy_d;

  logic                                 accept;
  logic                                 cfg_write;
  basr_pkg::reg_idx_e                   cfg_idx;

  logic                                 step_sck;
  logic                                 step_done;
  logic                                 step_busy;
  logic [SUM_W-1:0]                     step_sum;
  logic [CNT_W-1:0]                     step_taken;

  logic [PIDX_W-1:0]                    pidx_inc;
  logic [basr_pkg::GAIN_W-1:0]          gain_need;
  logic [CNT_W-1:0]                     count_need;
  logic [CNT_W-1:0]                     taken_inc;
  logic signed [SUM_W-1:0]              reading;
  logic [SUM_W-1:0]                     sum_new;

  logic [CNT_W:0]                       rem_sh;
  logic [CNT_W:0]                       rem_sub;
  logic                                 rem_ge;

  logic signed [basr_pkg::EXT_W-1:0]    avg_ext;
  logic signed [basr_pkg::EXT_W-1:0]    off_ext;
  logic signed [basr_pkg::EXT_W-1:0]    net_ext;
  logic signed [basr_pkg::EXT_W-1:0]    net_sat;

  assign accept    = in_valid_i && in_ready_o;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = basr_pkg::reg_idx_e'(paddr[basr_pkg::PADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      basr_pkg::REG_GAIN_PULSES: prdata = basr_pkg::PDATA_W'(gain_q);
      basr_pkg::REG_AVG_COUNT:   prdata = basr_pkg::PDATA_W'(avg_count_q);
      basr_pkg::REG_ZERO_OFFSET: prdata = basr_pkg::PDATA_W'(signed'(offset_q));
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= basr_pkg::GAIN_W'(1);
      avg_count_q <= CNT_W'(1);
      offset_q    <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        basr_pkg::REG_GAIN_PULSES: gain_q      <= pwdata[basr_pkg::GAIN_W-1:0];
        basr_pkg::REG_AVG_COUNT:   avg_count_q <= pwdata[CNT_W-1:0];
        basr_pkg::REG_ZERO_OFFSET: offset_q    <= pwdata[basr_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Readout step for one half period of the serial clock.
  assign pidx_inc   = pidx_q + PIDX_W'(1);
  assign gain_need  = (gain_q == '0) ? basr_pkg::GAIN_W'(1) : gain_q;
  assign count_need = (avg_count_q == '0) ? CNT_W'(1) : avg_count_q;
  assign taken_inc  = taken_q + CNT_W'(1);
  assign reading    = SUM_W'(signed'(shift_q));
  assign sum_new    = sum_q + reading;

  always_comb begin
    phase_d    = phase_q;
    clk_high_d = clk_high_q;
    pidx_d     = pidx_q;
    shift_d    = shift_q;
    sum_d      = sum_q;
    taken_d    = taken_q;
    step_sck   = 1'b0;
    step_done  = 1'b0;
    step_sum   = sum_new;
    step_taken = taken_inc;
    if (phase_q == basr_pkg::PH_IDLE) begin
      if (!dout_level_i) begin
        phase_d    = basr_pkg::PH_DATA;
        pidx_d     = '0;
        shift_d    = '0;
        clk_high_d = 1'b1;
        step_sck   = 1'b1;
      end
    end else if (!clk_high_q) begin
      clk_high_d = 1'b1;
      step_sck   = 1'b1;
    end else if (phase_q == basr_pkg::PH_DATA) begin
      shift_d    = {shift_q[DATA_BITS-2:0], dout_level_i};
      pidx_d     = pidx_inc;
      clk_high_d = 1'b0;
      if (pidx_inc >= PIDX_W'(DATA_BITS)) begin
        phase_d = basr_pkg::PH_GAIN;
        pidx_d  = '0;
      end
    end else begin
      pidx_d     = pidx_inc;
      clk_high_d = 1'b0;
      if (pidx_inc >= PIDX_W'(gain_need)) begin
        phase_d = basr_pkg::PH_IDLE;
        pidx_d  = '0;
        sum_d   = sum_new;
        taken_d = taken_inc;
        if (taken_inc >= count_need) begin
          step_done = 1'b1;
          sum_d     = '0;
          taken_d   = '0;
        end
      end
    end
    step_busy = (phase_d != basr_pkg::PH_IDLE);
  end

  // Restoring divider: one quotient bit per cycle.
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor_q});
  assign rem_sub = rem_sh - {1'b0, divisor_q};

  assign avg_ext = neg_q ? -signed'(basr_pkg::EXT_W'(quo_q))
                         : signed'(basr_pkg::EXT_W'(quo_q));
  assign off_ext = basr_pkg::EXT_W'(signed'(offset_q));
  assign net_ext = avg_ext - off_ext;

  always_comb begin
    if (net_ext > basr_pkg::NET_MAX) begin
      net_sat = basr_pkg::NET_MAX;
    end else if (net_ext < basr_pkg::NET_MIN) begin
      net_sat = basr_pkg::NET_MIN;
    end else begin
      net_sat = net_ext;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      basr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = step_done ? basr_pkg::ST_DIV : basr_pkg::ST_OUT;
        end
      end
      basr_pkg::ST_DIV: begin
        if (div_cnt_q == '1) begin
          state_d = basr_pkg::ST_FIN;
        end
      end
      basr_pkg::ST_FIN: state_d = basr_pkg::ST_OUT;
      basr_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = basr_pkg::ST_IDLE;
        end
      end
      default: state_d = basr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == basr_pkg::ST_IDLE);
    out_valid_o = (state_q == basr_pkg::ST_OUT);
  end

  always_comb begin
    div_cnt_d = div_cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    neg_d     = neg_q;
    sck_d     = sck_q;
    valid_d   = valid_q;
    net_d     = net_q;
    busy_d    = busy_q;
    case (state_q)
      basr_pkg::ST_IDLE: begin
        if (accept) begin
          sck_d     = step_sck;
          busy_d    = step_busy;
          valid_d   = step_done;
          net_d     = '0;
          div_cnt_d = '0;
          rem_d     = '0;
          divisor_d = step_taken;
          neg_d     = step_sum[SUM_W-1];
          quo_d     = step_sum[SUM_W-1] ? (~step_sum + SUM_W'(1)) : step_sum;
        end
      end
      basr_pkg::ST_DIV: begin
        div_cnt_d = div_cnt_q + basr_pkg::DIVCNT_W'(1);
        rem_d     = rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_d     = {quo_q[SUM_W-2:0], rem_ge};
      end
      basr_pkg::ST_FIN: begin
        net_d = net_sat[basr_pkg::NET_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= basr_pkg::ST_IDLE;
      phase_q    <= basr_pkg::PH_IDLE;
      clk_high_q <= 1'b0;
      pidx_q     <= '0;
      shift_q    <= '0;
      sum_q      <= '0;
      taken_q    <= '0;
      div_cnt_q  <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      divisor_q  <= '0;
      neg_q      <= 1'b0;
      sck_q      <= 1'b0;
      valid_q    <= 1'b0;
      net_q      <= '0;
      busy_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      quo_q     <= quo_d;
      rem_q     <= rem_d;
      divisor_q <= divisor_d;
      neg_q     <= neg_d;
      sck_q     <= sck_d;
      valid_q   <= valid_d;
      net_q     <= net_d;
      busy_q    <= busy_d;
      if (accept) begin
        phase_q    <= phase_d;
        clk_high_q <= clk_high_d;
        pidx_q     <= pidx_d;
        shift_q    <= shift_d;
        sum_q      <= sum_d;
        taken_q    <= taken_d;
      end
    end
  end

  assign sck_level_o    = sck_q;
  assign sample_valid_o = valid_q;
  assign net_value_o    = net_q;
  assign busy_res_o     = busy_q;

endmodule
